@@ design/crd_pkg.sv @@
package crd_pkg;

  localparam int VALUE_BITS   = 64;
  localparam int DEN_BITS     = 7;
  localparam int HALF_BITS    = VALUE_BITS / 2;
  localparam int PROD_BITS    = 2 * VALUE_BITS;
  localparam int SUM_BITS     = PROD_BITS + 1;
  localparam int BD_BITS      = VALUE_BITS + DEN_BITS;
  localparam int DIV_STEPS    = 4;
  localparam int DIV_STAGES   = PROD_BITS / DIV_STEPS;
  localparam int CFG_IDX_BITS = 3;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_CONST  = 2'd0;
  localparam mode_t MODE_DUP    = 2'd1;
  localparam mode_t MODE_AFFINE = 2'd2;
  localparam mode_t MODE_RESID  = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CONSTANT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLOPE_NUM = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLOPE_DEN = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTERCEPT = 3'd4;

  typedef struct packed {
    mode_t                 mode;
    logic [VALUE_BITS-1:0] constant_value;
    logic [VALUE_BITS-1:0] slope_num;
    logic [DEN_BITS-1:0]   slope_den;
    logic [VALUE_BITS-1:0] intercept;
  } cfg_t;

  // one word in flight through the divider
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic                  neg;
    logic [VALUE_BITS-1:0] plain;
    logic [PROD_BITS-1:0]  work;
    logic [DEN_BITS-1:0]   rem;
  } div_t;

endpackage

@@ design/crd_cfg.sv @@
module crd_cfg import crd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [VALUE_BITS-1:0]   cfg_data,
  output cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= MODE_CONST;
      cfg.constant_value <= '0;
      cfg.slope_num      <= VALUE_BITS'(1);
      cfg.slope_den      <= DEN_BITS'(1);
      cfg.intercept      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:      cfg.mode           <= cfg_data[1:0];
        REG_CONSTANT:  cfg.constant_value <= cfg_data;
        REG_SLOPE_NUM: cfg.slope_num      <= cfg_data;
        REG_SLOPE_DEN: cfg.slope_den      <= cfg_data[DEN_BITS-1:0];
        REG_INTERCEPT: cfg.intercept      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ design/crd_front.sv @@
module crd_front import crd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  input  logic [VALUE_BITS-1:0] src,
  input  logic [VALUE_BITS-1:0] res,
  input  logic                  last,
  output div_t                  dout
);

  // stage a: magnitudes, bypass value, intercept times denominator
  logic                  src_neg;
  logic                  num_neg;
  logic [VALUE_BITS-1:0] src_mag;
  logic [VALUE_BITS-1:0] num_mag;
  logic [VALUE_BITS-1:0] plain_next;
  logic [BD_BITS-1:0]    bd_next;

  logic                  a_valid;
  logic                  a_last;
  logic                  a_neg;
  logic [VALUE_BITS-1:0] a_plain;
  logic [VALUE_BITS-1:0] a_src_mag;
  logic [VALUE_BITS-1:0] a_num_mag;
  logic [BD_BITS-1:0]    a_bd;

  assign src_neg = src[VALUE_BITS-1];
  assign num_neg = cfg.slope_num[VALUE_BITS-1];
  assign src_mag = src_neg ? VALUE_BITS'(0) - src : src;
  assign num_mag = num_neg ? VALUE_BITS'(0) - cfg.slope_num : cfg.slope_num;
  assign bd_next = $signed({{DEN_BITS{cfg.intercept[VALUE_BITS-1]}}, cfg.intercept})
                 * $signed({{VALUE_BITS{1'b0}}, cfg.slope_den});

  always_comb begin
    case (cfg.mode)
      MODE_CONST: plain_next = cfg.constant_value;
      MODE_DUP:   plain_next = src;
      MODE_RESID: plain_next = src + res;
      default:    plain_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    a_valid   <= rst ? 1'b0 : in_valid;
    a_last    <= last;
    a_neg     <= src_neg ^ num_neg;
    a_plain   <= plain_next;
    a_src_mag <= src_mag;
    a_num_mag <= num_mag;
    a_bd      <= bd_next;
  end

  // stage b: four half-width partial products
  logic                  b_valid;
  logic                  b_last;
  logic                  b_neg;
  logic [VALUE_BITS-1:0] b_plain;
  logic [BD_BITS-1:0]    b_bd;
  logic [VALUE_BITS-1:0] pp_ll;
  logic [VALUE_BITS-1:0] pp_lh;
  logic [VALUE_BITS-1:0] pp_hl;
  logic [VALUE_BITS-1:0] pp_hh;

  always_ff @(posedge clk) begin
    b_valid <= rst ? 1'b0 : a_valid;
    b_last  <= a_last;
    b_neg   <= a_neg;
    b_plain <= a_plain;
    b_bd    <= a_bd;
    pp_ll   <= a_src_mag[HALF_BITS-1:0] * a_num_mag[HALF_BITS-1:0];
    pp_lh   <= a_src_mag[HALF_BITS-1:0] * a_num_mag[VALUE_BITS-1:HALF_BITS];
    pp_hl   <= a_src_mag[VALUE_BITS-1:HALF_BITS] * a_num_mag[HALF_BITS-1:0];
    pp_hh   <= a_src_mag[VALUE_BITS-1:HALF_BITS] * a_num_mag[VALUE_BITS-1:HALF_BITS];
  end

  // stage c: product magnitude
  logic                  c_valid;
  logic                  c_last;
  logic                  c_neg;
  logic [VALUE_BITS-1:0] c_plain;
  logic [BD_BITS-1:0]    c_bd;
  logic [PROD_BITS-1:0]  c_mag;

  always_ff @(posedge clk) begin
    c_valid <= rst ? 1'b0 : b_valid;
    c_last  <= b_last;
    c_neg   <= b_neg;
    c_plain <= b_plain;
    c_bd    <= b_bd;
    c_mag   <= {pp_hh, pp_ll} + (PROD_BITS'(pp_lh) << HALF_BITS)
             + (PROD_BITS'(pp_hl) << HALF_BITS);
  end

  // stage d: signed numerator
  logic [SUM_BITS-1:0]   prod_s;
  logic                  d_valid;
  logic                  d_last;
  logic [VALUE_BITS-1:0] d_plain;
  logic [SUM_BITS-1:0]   d_sum;

  assign prod_s = c_neg ? SUM_BITS'(0) - {1'b0, c_mag} : {1'b0, c_mag};

  always_ff @(posedge clk) begin
    d_valid <= rst ? 1'b0 : c_valid;
    d_last  <= c_last;
    d_plain <= c_plain;
    d_sum   <= prod_s + {{(SUM_BITS-BD_BITS){c_bd[BD_BITS-1]}}, c_bd};
  end

  // stage e: magnitude into the divider
  logic [SUM_BITS-1:0] sum_mag;

  assign sum_mag = d_sum[SUM_BITS-1] ? SUM_BITS'(0) - d_sum : d_sum;

  always_ff @(posedge clk) begin
    dout.valid <= rst ? 1'b0 : d_valid;
    dout.last  <= d_last;
    dout.neg   <= d_sum[SUM_BITS-1];
    dout.plain <= d_plain;
    dout.work  <= sum_mag[PROD_BITS-1:0];
    dout.rem   <= '0;
  end

endmodule

@@ design/crd_div_stage.sv @@
module crd_div_stage import crd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [DEN_BITS-1:0] den,
  input  div_t                din,
  output div_t                dout
);

  div_t              dout_next;
  logic [DEN_BITS:0] part;

  // restoring steps: dividend shifts out the top, quotient in at the bottom
  always_comb begin
    dout_next = din;
    part      = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      part           = {dout_next.rem, dout_next.work[PROD_BITS-1]};
      dout_next.work = {dout_next.work[PROD_BITS-2:0], 1'b0};
      if (part >= {1'b0, den}) begin
        part              = part - {1'b0, den};
        dout_next.work[0] = 1'b1;
      end
      dout_next.rem = part[DEN_BITS-1:0];
    end
    if (rst) begin
      dout_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

@@ design/column_reconstruct_decoder_top.sv @@
// Column reconstruct decoder: rebuilds one point of a dropped column per word.
// Input: a word is taken at a rising edge with start high and busy low. busy
// is never raised, so a word may be started in every cycle.
// Config: cfg_valid/cfg_ready write channel, cfg_index picks the register
// (0 mode, 1 constant_value, 2 slope_num, 3 slope_den, 4 intercept), higher
// indexes are ignored. cfg_ready is always high. Write only while no word is
// in flight.
// Output: done is high for one cycle with target_value, den_zero_error and
// last_out; the receiver cannot stall and every result appears exactly once.
// Throughput: one word per cycle. Every mode passes through the same path:
// front stages a to e (operand magnitudes, 32x32 partial products, product
// sum, signed numerator, divider input magnitude), then the radix-2 division
// stages at 4 bits per stage over the 128-bit numerator, and one output
// register.
// Reset: clears the pipeline valid bits and loads the register reset values
// (mode constant, constant 0, slope 1/1, intercept 0).
module column_reconstruct_decoder_top import crd_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_BITS-1:0]  source_value,
  input  logic signed [VALUE_BITS-1:0]  residual_value,
  input  logic                          last_in,
  output logic                          done,
  output logic signed [VALUE_BITS-1:0]  target_value,
  output logic                          den_zero_error,
  output logic                          last_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [VALUE_BITS-1:0]         cfg_data
);

  cfg_t cfg;
  div_t pipe [DIV_STAGES+1];

  assign busy = 1'b0;

  crd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  crd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (start && !busy),
    .src      (source_value),
    .res      (residual_value),
    .last     (last_in),
    .dout     (pipe[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    crd_div_stage u_stage (
      .clk  (clk),
      .rst  (rst),
      .den  (cfg.slope_den),
      .din  (pipe[g]),
      .dout (pipe[g+1])
    );
  end

  logic [VALUE_BITS-1:0] quot;
  logic [VALUE_BITS-1:0] affine_val;
  logic                  den_zero;

  assign quot       = pipe[DIV_STAGES].work[VALUE_BITS-1:0];
  assign den_zero   = (cfg.slope_den == '0);
  assign affine_val = den_zero ? '0
                    : (pipe[DIV_STAGES].neg ? VALUE_BITS'(0) - quot : quot);

  always_ff @(posedge clk) begin
    done           <= rst ? 1'b0 : pipe[DIV_STAGES].valid;
    last_out       <= pipe[DIV_STAGES].last;
    den_zero_error <= pipe[DIV_STAGES].valid && (cfg.mode == MODE_AFFINE) && den_zero;
    target_value   <= (cfg.mode == MODE_AFFINE) ? affine_val : pipe[DIV_STAGES].plain;
  end

  a_err_with_done: assert property (@(posedge clk) disable iff (rst)
    den_zero_error |-> done)
    else $error("error flag without a result");

  a_err_zero_value: assert property (@(posedge clk) disable iff (rst)
    (done && den_zero_error) |-> (target_value == '0))
    else $error("zero denominator result not cleared");

  a_err_only_affine: assert property (@(posedge clk) disable iff (rst)
    (done && cfg.mode != MODE_AFFINE) |-> !den_zero_error)
    else $error("error flag outside affine mode");

endmodule
